// ===== hw/rtl/cube_map_texel_address_top_assert.svh =====
// assertion macros for the cube map address block
`ifndef CUBE_MAP_TEXEL_ADDRESS_TOP_ASSERT_SVH
`define CUBE_MAP_TEXEL_ADDRESS_TOP_ASSERT_SVH

// same-cycle implication
`define CMTA_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CMTA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cmta_pkg.sv =====
package cmta_pkg;

  localparam int DIR_W     = 16;
  localparam int MAG_W     = 16;
  localparam int SUM_W     = 17;
  localparam int DEN_W     = MAG_W + 1;
  localparam int SIZE_W    = 13;
  localparam int NUM_W     = DEN_W + SIZE_W;
  localparam int FACE_W    = 3;
  localparam int COORD_W   = 12;
  localparam int FRAC_W    = 12;
  localparam int MID_DEPTH = 4;

  localparam int MAX_FACE_SIZE_DEF = 4096;
  localparam int FRAC_BITS_DEF     = 12;

  localparam logic [SIZE_W-1:0] FACE_SIZE_RESET = 13'd256;

  localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
  localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
  localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

  // classified direction handed from front to back
  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic              zero;
    logic [MAG_W-1:0]  mag;
    logic [SUM_W-1:0]  sum_u;
    logic [SUM_W-1:0]  sum_v;
    logic [SIZE_W-1:0] size;
  } item_t;

  typedef struct packed {
    logic [FACE_W-1:0]  face;
    logic [COORD_W-1:0] col_lo;
    logic [COORD_W-1:0] col_hi;
    logic [COORD_W-1:0] row_lo;
    logic [COORD_W-1:0] row_hi;
    logic [FRAC_W-1:0]  frac_col;
    logic [FRAC_W-1:0]  frac_row;
    logic               zero;
  } result_t;

endpackage

// ===== hw/rtl/cmta_front.sv =====
module cmta_front #(
  parameter int MAX_FACE_SIZE = cmta_pkg::MAX_FACE_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [cmta_pkg::DIR_W-1:0] dir_x,
  input  logic signed [cmta_pkg::DIR_W-1:0] dir_y,
  input  logic signed [cmta_pkg::DIR_W-1:0] dir_z,
  input  logic [cmta_pkg::SIZE_W-1:0]       face_size,
  output logic                              item_valid,
  output cmta_pkg::item_t                   item,
  input  logic                              item_ready
);

  logic [cmta_pkg::MAG_W-1:0]         ax, ay, az, mag;
  logic signed [cmta_pkg::SUM_W:0]    px, py, pz, nu, nv;
  logic [cmta_pkg::SUM_W:0]           su, sv;
  logic                               x_major, y_major;
  logic [cmta_pkg::FACE_W-1:0]        face;
  logic [cmta_pkg::SIZE_W-1:0]        size_eff;
  logic                               front_ready;
  cmta_pkg::item_t                    item_next;

  assign front_ready = !item_valid || item_ready;
  assign full        = !front_ready;

  always_comb begin
    ax = dir_x[cmta_pkg::DIR_W-1] ? (cmta_pkg::MAG_W'(~dir_x) + cmta_pkg::MAG_W'(1))
                                  : cmta_pkg::MAG_W'(dir_x);
    ay = dir_y[cmta_pkg::DIR_W-1] ? (cmta_pkg::MAG_W'(~dir_y) + cmta_pkg::MAG_W'(1))
                                  : cmta_pkg::MAG_W'(dir_y);
    az = dir_z[cmta_pkg::DIR_W-1] ? (cmta_pkg::MAG_W'(~dir_z) + cmta_pkg::MAG_W'(1))
                                  : cmta_pkg::MAG_W'(dir_z);
    px = (cmta_pkg::SUM_W+1)'(dir_x);
    py = (cmta_pkg::SUM_W+1)'(dir_y);
    pz = (cmta_pkg::SUM_W+1)'(dir_z);
    x_major = (ax >= ay) && (ax >= az);
    y_major = ay >= az;

    // ties go to x, then y
    priority if (x_major) begin
      mag = ax;
      if (!dir_x[cmta_pkg::DIR_W-1]) begin
        face = cmta_pkg::FACE_POS_X;
        nu   = -pz;
        nv   = -py;
      end else begin
        face = cmta_pkg::FACE_NEG_X;
        nu   = pz;
        nv   = -py;
      end
    end else if (y_major) begin
      mag = ay;
      if (!dir_y[cmta_pkg::DIR_W-1]) begin
        face = cmta_pkg::FACE_POS_Y;
        nu   = px;
        nv   = pz;
      end else begin
        face = cmta_pkg::FACE_NEG_Y;
        nu   = px;
        nv   = -pz;
      end
    end else begin
      mag = az;
      if (!dir_z[cmta_pkg::DIR_W-1]) begin
        face = cmta_pkg::FACE_POS_Z;
        nu   = px;
        nv   = -py;
      end else begin
        face = cmta_pkg::FACE_NEG_Z;
        nu   = -px;
        nv   = -py;
      end
    end

    // shift numerators into [0, 2m]
    su = nu + (cmta_pkg::SUM_W+1)'(mag);
    sv = nv + (cmta_pkg::SUM_W+1)'(mag);

    if (face_size == '0) begin
      size_eff = cmta_pkg::SIZE_W'(1);
    end else if (32'(face_size) > MAX_FACE_SIZE) begin
      size_eff = cmta_pkg::SIZE_W'(MAX_FACE_SIZE);
    end else begin
      size_eff = face_size;
    end

    item_next.face  = face;
    item_next.zero  = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
    item_next.mag   = mag;
    item_next.sum_u = su[cmta_pkg::SUM_W-1:0];
    item_next.sum_v = sv[cmta_pkg::SUM_W-1:0];
    item_next.size  = size_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (front_ready) begin
      item_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && front_ready) begin
      item <= item_next;
    end
  end

endmodule

// ===== hw/rtl/cmta_fifo.sv =====
module cmta_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  input  cmta_pkg::item_t wr_data,
  output logic            wr_ready,
  output logic            rd_valid,
  output cmta_pkg::item_t rd_data,
  input  logic            rd_pop
);

  localparam int PTR_W = $clog2(cmta_pkg::MID_DEPTH);
  localparam int CNT_W = $clog2(cmta_pkg::MID_DEPTH + 1);

  cmta_pkg::item_t  slots [cmta_pkg::MID_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(cmta_pkg::MID_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign wr_ready = count != CNT_W'(cmta_pkg::MID_DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= next_ptr(wr_ptr);
      end
      if (do_rd) begin
        rd_ptr <= next_ptr(rd_ptr);
      end
      count <= count + CNT_W'(do_wr) - CNT_W'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== hw/rtl/cmta_div.sv =====
module cmta_div #(
  parameter int FRAC_BITS = cmta_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic [cmta_pkg::NUM_W-1:0]              num,
  input  logic [cmta_pkg::DEN_W-1:0]              den,
  output logic [cmta_pkg::SIZE_W+FRAC_BITS-1:0]   quot
);

  localparam int QW = cmta_pkg::SIZE_W + FRAC_BITS;

  logic [cmta_pkg::DEN_W-1:0] rem  [QW];
  logic [QW-1:0]              work [QW];
  logic [cmta_pkg::DEN_W-1:0] dv   [QW];

  // one quotient bit per stage; dividend is num scaled by 2^FRAC_BITS
  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [cmta_pkg::DEN_W-1:0] r_in, d_in;
    logic [QW-1:0]              w_in;
    logic [cmta_pkg::DEN_W:0]   trial, diff;
    logic                       take;

    if (i == 0) begin : g_first
      assign r_in = num[cmta_pkg::NUM_W-1 -: cmta_pkg::DEN_W];
      assign w_in = {num[cmta_pkg::SIZE_W-1:0], {FRAC_BITS{1'b0}}};
      assign d_in = den;
    end else begin : g_next
      assign r_in = rem[i-1];
      assign w_in = work[i-1];
      assign d_in = dv[i-1];
    end

    assign trial = {r_in, w_in[QW-1]};
    assign diff  = trial - {1'b0, d_in};
    assign take  = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= take ? diff[cmta_pkg::DEN_W-1:0] : trial[cmta_pkg::DEN_W-1:0];
        work[i] <= {w_in[QW-2:0], take};
        dv[i]   <= d_in;
      end
    end
  end

  assign quot = work[QW-1];

endmodule

// ===== hw/rtl/cmta_back.sv =====
module cmta_back #(
  parameter int FRAC_BITS = cmta_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  cmta_pkg::item_t   in_item,
  output logic              in_pop,
  output logic              res_valid,
  output cmta_pkg::result_t res,
  input  logic              res_pop
);

  localparam int QW = cmta_pkg::SIZE_W + FRAC_BITS;

  typedef struct packed {
    logic [cmta_pkg::FACE_W-1:0] face;
    logic                        zero;
    logic [cmta_pkg::SIZE_W-1:0] size;
  } side_t;

  logic                       advance;
  logic                       m_valid;
  side_t                      m_side;
  logic [cmta_pkg::NUM_W-1:0] m_num_u, m_num_v;
  logic [cmta_pkg::DEN_W-1:0] m_den;
  logic [QW-1:0]              quot_u, quot_v;
  logic [QW-1:0]              d_valid;
  side_t                      d_side [QW];
  side_t                      last;
  logic [cmta_pkg::SIZE_W-1:0] q_u, q_v;
  cmta_pkg::result_t          res_next;

  function automatic logic [cmta_pkg::COORD_W-1:0] coord_lo(
    input logic [cmta_pkg::SIZE_W-1:0] q
  );
    return (q == '0) ? '0 : cmta_pkg::COORD_W'(q - cmta_pkg::SIZE_W'(1));
  endfunction

  function automatic logic [cmta_pkg::COORD_W-1:0] coord_hi(
    input logic [cmta_pkg::SIZE_W-1:0] q,
    input logic [cmta_pkg::SIZE_W-1:0] size
  );
    return (q >= size) ? cmta_pkg::COORD_W'(size - cmta_pkg::SIZE_W'(1))
                       : cmta_pkg::COORD_W'(q);
  endfunction

  function automatic logic [cmta_pkg::FRAC_W-1:0] frac_out(
    input logic [FRAC_BITS-1:0] f
  );
    logic [FRAC_BITS+cmta_pkg::FRAC_W-1:0] wide;
    wide = {{cmta_pkg::FRAC_W{1'b0}}, f};
    return wide[cmta_pkg::FRAC_W-1:0];
  endfunction

  // whole back pipeline moves together while the output slot is empty or being popped
  assign advance = !res_valid || res_pop;
  assign in_pop  = advance && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      d_valid   <= '0;
      res_valid <= 1'b0;
    end else if (advance) begin
      m_valid   <= in_valid;
      d_valid   <= {d_valid[QW-2:0], m_valid};
      res_valid <= d_valid[QW-1];
    end
  end

  // numerator (n+m)*size + m over denominator 2m
  always_ff @(posedge clk) begin
    if (advance) begin
      m_side.face <= in_item.face;
      m_side.zero <= in_item.zero;
      m_side.size <= in_item.size;
      m_num_u <= cmta_pkg::NUM_W'(in_item.sum_u) * cmta_pkg::NUM_W'(in_item.size)
               + cmta_pkg::NUM_W'(in_item.mag);
      m_num_v <= cmta_pkg::NUM_W'(in_item.sum_v) * cmta_pkg::NUM_W'(in_item.size)
               + cmta_pkg::NUM_W'(in_item.mag);
      m_den   <= {in_item.mag, 1'b0};
      d_side[0] <= m_side;
      for (int i = 1; i < QW; i++) begin
        d_side[i] <= d_side[i-1];
      end
      res <= res_next;
    end
  end

  cmta_div #(.FRAC_BITS(FRAC_BITS)) u_div_u (
    .clk  (clk),
    .en   (advance),
    .num  (m_num_u),
    .den  (m_den),
    .quot (quot_u)
  );

  cmta_div #(.FRAC_BITS(FRAC_BITS)) u_div_v (
    .clk  (clk),
    .en   (advance),
    .num  (m_num_v),
    .den  (m_den),
    .quot (quot_v)
  );

  always_comb begin
    last = d_side[QW-1];
    q_u  = quot_u[QW-1 -: cmta_pkg::SIZE_W];
    q_v  = quot_v[QW-1 -: cmta_pkg::SIZE_W];
    res_next      = '0;
    res_next.zero = last.zero;
    if (!last.zero) begin
      res_next.face     = last.face;
      res_next.col_lo   = coord_lo(q_u);
      res_next.col_hi   = coord_hi(q_u, last.size);
      res_next.row_lo   = coord_lo(q_v);
      res_next.row_hi   = coord_hi(q_v, last.size);
      res_next.frac_col = frac_out(quot_u[FRAC_BITS-1:0]);
      res_next.frac_row = frac_out(quot_v[FRAC_BITS-1:0]);
    end
  end

endmodule

// ===== hw/rtl/cube_map_texel_address_top.sv =====
// cube map face select and bilinear texel addressing
// path: front register, queue, multiply stage, divider stages, result register
// throughput: one direction per cycle when not stalled; one quotient bit per divider stage
// pop low with a result waiting stalls the back; the 4-beat queue and front stage still fill
// rst is synchronous: clears all valid state and loads face_size with 256
`include "cube_map_texel_address_top_assert.svh"

module cube_map_texel_address_top #(
  parameter int MAX_FACE_SIZE = cmta_pkg::MAX_FACE_SIZE_DEF,
  parameter int FRAC_BITS     = cmta_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [cmta_pkg::SIZE_W-1:0]         cfg_data,
  input  logic                                push,
  output logic                                full,
  input  logic signed [cmta_pkg::DIR_W-1:0]   dir_x,
  input  logic signed [cmta_pkg::DIR_W-1:0]   dir_y,
  input  logic signed [cmta_pkg::DIR_W-1:0]   dir_z,
  output logic                                empty,
  input  logic                                pop,
  output logic [cmta_pkg::FACE_W-1:0]         face_index,
  output logic [cmta_pkg::COORD_W-1:0]        col_lo,
  output logic [cmta_pkg::COORD_W-1:0]        col_hi,
  output logic [cmta_pkg::COORD_W-1:0]        row_lo,
  output logic [cmta_pkg::COORD_W-1:0]        row_hi,
  output logic [cmta_pkg::FRAC_W-1:0]         frac_col,
  output logic [cmta_pkg::FRAC_W-1:0]         frac_row,
  output logic                                zero_direction
);

  logic [cmta_pkg::SIZE_W-1:0] face_size;
  logic                        front_valid;
  cmta_pkg::item_t             front_item;
  logic                        mid_ready;
  logic                        mid_valid;
  cmta_pkg::item_t             mid_item;
  logic                        mid_pop;
  logic                        res_valid;
  cmta_pkg::result_t           res;

  always_ff @(posedge clk) begin
    if (rst) begin
      face_size <= cmta_pkg::FACE_SIZE_RESET;
    end else if (cfg_write) begin
      face_size <= cfg_data;
    end
  end

  cmta_front #(.MAX_FACE_SIZE(MAX_FACE_SIZE)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .dir_x      (dir_x),
    .dir_y      (dir_y),
    .dir_z      (dir_z),
    .face_size  (face_size),
    .item_valid (front_valid),
    .item       (front_item),
    .item_ready (mid_ready)
  );

  cmta_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_data  (front_item),
    .wr_ready (mid_ready),
    .rd_valid (mid_valid),
    .rd_data  (mid_item),
    .rd_pop   (mid_pop)
  );

  cmta_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_item   (mid_item),
    .in_pop    (mid_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (pop)
  );

  assign empty          = !res_valid;
  assign face_index     = res.face;
  assign col_lo         = res.col_lo;
  assign col_hi         = res.col_hi;
  assign row_lo         = res.row_lo;
  assign row_hi         = res.row_hi;
  assign frac_col       = res.frac_col;
  assign frac_row       = res.frac_row;
  assign zero_direction = res.zero;

  `CMTA_ASSERT_IMPLIES(a_stall_holds_queue, clk, rst, !empty && !pop, !mid_pop,
    "queue popped while output is stalled")
  `CMTA_ASSERT_IMPLIES(a_face_code, clk, rst, !empty, face_index <= cmta_pkg::FACE_NEG_Z,
    "face index out of range")
  `CMTA_ASSERT_IMPLIES(a_zero_result, clk, rst, !empty && zero_direction,
    face_index == cmta_pkg::FACE_POS_X && col_lo == '0 && col_hi == '0
      && row_lo == '0 && row_hi == '0 && frac_col == '0 && frac_row == '0,
    "zero direction with nonzero fields")
  `CMTA_ASSERT_NEXT(a_accept_fills_front, clk, rst, push && !full, front_valid,
    "accepted beat not held in front stage")

endmodule
